// ----- hw/rtl/crmf_pkg.sv -----
package crmf_pkg;

    // Window store depth and sample width
    localparam int MAX_WINDOW  = 31;
    localparam int SAMPLE_BITS = 16;
    localparam int VALUE_BITS  = 17;
    localparam int SUM_BITS    = SAMPLE_BITS + 1;

    // Counter and index widths
    localparam int CNT_BITS = $clog2(MAX_WINDOW + 1);
    localparam int IDX_BITS = $clog2(MAX_WINDOW);

    // Results per input transaction are capped
    localparam int RESULT_CAP = 16;
    localparam int RES_BITS   = $clog2(RESULT_CAP + 1);

    // Configuration port
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 5;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_WINDOW_SIZE   = 2'd0,
        REG_RESIDUAL_MODE = 2'd1
    } cfg_reg_t;

    localparam logic [CFG_DATA_BITS-1:0] WINDOW_SIZE_RESET = 5'd5;

    // Commands from controller to datapath
    typedef struct packed {
        logic                load_sample;
        logic                shift;
        logic                cmp;
        logic [IDX_BITS-1:0] idx;
        logic                load_out;
    } crmf_cmd_t;

endpackage

// ----- hw/rtl/crmf_if.sv -----
interface crmf_sample_if;
    import crmf_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface crmf_result_if;
    import crmf_pkg::*;
    logic                         valid;
    logic                         ready;
    logic signed [VALUE_BITS-1:0] value;
    logic                         last_result;

    modport source (output valid, output value, output last_result, input ready);
    modport sink   (input valid, input value, input last_result, output ready);
endinterface

interface crmf_cfg_if;
    import crmf_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- hw/rtl/crmf_ctrl.sv -----
module crmf_ctrl
    import crmf_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CNT_BITS-1:0] n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                in_last,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_last,
    output crmf_cmd_t           cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_RANK,
        S_DRAIN,
        S_EMIT
    } state_t;

    state_t              state_reg;
    logic                last_reg;
    logic                started_reg;
    logic                push_final_reg;
    logic [CNT_BITS-1:0] push_left_reg;
    logic [CNT_BITS-1:0] fill_reg;
    logic [RES_BITS-1:0] res_cnt_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic                out_valid_reg;
    logic                out_last_reg;

    logic [CNT_BITS-1:0] half;
    logic [CNT_BITS-1:0] front;
    logic [CNT_BITS-1:0] tail;
    logic [CNT_BITS-1:0] fill_inc;
    logic                accept;
    logic                can_load;

    // Padding counts for the window in use
    assign half     = n >> 1;
    assign front    = started_reg ? '0 : half;
    assign tail     = in_last ? (n - CNT_BITS'(1) - half) : '0;
    assign fill_inc = (fill_reg < CNT_BITS'(MAX_WINDOW)) ? (fill_reg + CNT_BITS'(1)) : fill_reg;

    assign in_ready = (state_reg == S_IDLE);
    assign accept   = in_valid && in_ready;
    assign can_load = !out_valid_reg || out_ready;

    // Commands to the datapath
    always_comb
    begin
        cmd             = '0;
        cmd.load_sample = accept;
        cmd.shift       = (state_reg == S_PUSH);
        cmd.cmp         = (state_reg == S_RANK);
        cmd.idx         = idx_reg;
        cmd.load_out    = (state_reg == S_EMIT) && can_load;
    end

    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;

    // Sequence pushes, rank passes and result hand-off
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            last_reg       <= 1'b0;
            started_reg    <= 1'b0;
            push_final_reg <= 1'b0;
            push_left_reg  <= '0;
            fill_reg       <= '0;
            res_cnt_reg    <= '0;
            idx_reg        <= '0;
            out_valid_reg  <= 1'b0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            // Drop the result once the transaction completes
            if (out_valid_reg && out_ready && !cmd.load_out)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        last_reg      <= in_last;
                        started_reg   <= 1'b1;
                        push_left_reg <= front + tail + CNT_BITS'(1);
                        res_cnt_reg   <= '0;
                        state_reg     <= S_PUSH;
                    end
                end
                S_PUSH:
                begin
                    push_left_reg  <= push_left_reg - CNT_BITS'(1);
                    push_final_reg <= (push_left_reg == CNT_BITS'(1));
                    idx_reg        <= '0;
                    if (fill_inc >= n && res_cnt_reg < RES_BITS'(RESULT_CAP))
                    begin
                        fill_reg  <= fill_inc;
                        state_reg <= S_RANK;
                    end
                    else if (push_left_reg == CNT_BITS'(1))
                    begin
                        if (last_reg)
                        begin
                            fill_reg    <= '0;
                            started_reg <= 1'b0;
                        end
                        else
                            fill_reg <= fill_inc;
                        state_reg <= S_IDLE;
                    end
                    else
                        fill_reg <= fill_inc;
                end
                S_RANK:
                begin
                    idx_reg <= idx_reg + IDX_BITS'(1);
                    if (idx_reg == IDX_BITS'(n - CNT_BITS'(1)))
                        state_reg <= S_DRAIN;
                end
                S_DRAIN:
                begin
                    state_reg <= S_EMIT;
                end
                S_EMIT:
                begin
                    if (can_load)
                    begin
                        out_valid_reg <= 1'b1;
                        out_last_reg  <= last_reg && push_final_reg;
                        res_cnt_reg   <= res_cnt_reg + RES_BITS'(1);
                        if (push_final_reg)
                        begin
                            if (last_reg)
                            begin
                                fill_reg    <= '0;
                                started_reg <= 1'b0;
                            end
                            state_reg <= S_IDLE;
                        end
                        else
                            state_reg <= S_PUSH;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- hw/rtl/crmf_dp.sv -----
module crmf_dp
    import crmf_pkg::*;
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  crmf_cmd_t                     cmd,
    input  logic [CNT_BITS-1:0]           n,
    input  logic                          residual,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    output logic signed [VALUE_BITS-1:0]  value
);

    logic signed [SAMPLE_BITS-1:0] sample_reg;
    logic signed [SAMPLE_BITS-1:0] tap_reg [MAX_WINDOW];
    logic signed [SAMPLE_BITS-1:0] cand_reg;
    logic [MAX_WINDOW-1:0]         lt_reg;
    logic [MAX_WINDOW-1:0]         le_reg;
    logic                          cnt_valid_reg;
    logic signed [SAMPLE_BITS-1:0] lo_reg;
    logic signed [SAMPLE_BITS-1:0] hi_reg;
    logic signed [VALUE_BITS-1:0]  value_reg;

    logic signed [SAMPLE_BITS-1:0] cand;
    logic [MAX_WINDOW-1:0]         lt_vec;
    logic [MAX_WINDOW-1:0]         le_vec;
    logic [CNT_BITS-1:0]           lt_cnt;
    logic [CNT_BITS-1:0]           le_cnt;
    logic [CNT_BITS-1:0]           k_lo;
    logic [CNT_BITS-1:0]           k_hi;
    logic [IDX_BITS-1:0]           centre_idx;
    logic signed [SUM_BITS-1:0]    mid_sum;
    logic signed [SUM_BITS-1:0]    med;
    logic signed [SUM_BITS-1:0]    resid;

    function automatic logic [CNT_BITS-1:0] count_ones(input logic [MAX_WINDOW-1:0] v);
        logic [CNT_BITS-1:0] c;
        c = '0;
        for (int i = 0; i < MAX_WINDOW; i++)
            c = c + CNT_BITS'(v[i]);
        return c;
    endfunction

    // Hold the accepted sample and advance the window line, newest at tap 0
    always_ff @(posedge clk)
    begin
        if (cmd.load_sample)
            sample_reg <= in_sample;
        if (cmd.shift)
        begin
            tap_reg[0] <= sample_reg;
            for (int i = 1; i < MAX_WINDOW; i++)
                tap_reg[i] <= tap_reg[i-1];
        end
    end

    // Compare one candidate against every tap inside the window
    assign cand = tap_reg[cmd.idx];
    always_comb
    begin
        for (int j = 0; j < MAX_WINDOW; j++)
        begin
            lt_vec[j] = (CNT_BITS'(j) < n) && (tap_reg[j] <  cand);
            le_vec[j] = (CNT_BITS'(j) < n) && (tap_reg[j] <= cand);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cmp)
        begin
            cand_reg <= cand;
            lt_reg   <= lt_vec;
            le_reg   <= le_vec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_valid_reg <= 1'b0;
        else
            cnt_valid_reg <= cmd.cmp;
    end

    // Rank the candidate and keep it if it sits at either middle position
    assign lt_cnt = count_ones(lt_reg);
    assign le_cnt = count_ones(le_reg);
    assign k_lo   = (n - CNT_BITS'(1)) >> 1;
    assign k_hi   = n >> 1;

    always_ff @(posedge clk)
    begin
        if (cnt_valid_reg)
        begin
            if (lt_cnt <= k_lo && k_lo < le_cnt)
                lo_reg <= cand_reg;
            if (lt_cnt <= k_hi && k_hi < le_cnt)
                hi_reg <= cand_reg;
        end
    end

    // Average the middle pair (floor) and take the residual if asked
    assign centre_idx = IDX_BITS'(n - CNT_BITS'(1) - (n >> 1));
    assign mid_sum    = SUM_BITS'(lo_reg) + SUM_BITS'(hi_reg);
    assign med        = mid_sum >>> 1;
    assign resid      = med - SUM_BITS'(tap_reg[centre_idx]);

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
            value_reg <= residual ? VALUE_BITS'(resid) : VALUE_BITS'(med);
    end

    assign value = value_reg;

endmodule

// ----- hw/rtl/centered_rolling_median_filter.sv -----
// Centred rolling median filter over one signal of signed 16-bit samples.
// Channels: sample_in takes a sample and a last_sample flag; result_out gives
// a 17-bit value and last_result; cfg writes window_size (index 0, reset 5)
// and residual_mode (index 1, reset 0) and is always ready. Write cfg only
// while the block is idle between signals.
// The first sample of a signal is pushed n/2 extra times as front padding;
// a sample marked last is followed by n-1-n/2 further copies of itself, and
// the final result carries last_result. Each push that fills the window
// yields one result (at most 16 per input transaction).
// A result follows its push through a rank pass that compares one window
// entry against all taps of the window per cycle, then a drain step and
// the emit step. A plain sample in steady state goes through accept, push,
// rank pass, drain and emit. The next sample is accepted once all pushes
// of the current one are done and their results are loaded for output.
// A result waits in the output register while the receiver stalls; the
// next result is held back until it is taken.
// Reset clears the controller, fill count and configuration registers; the
// window line is refilled from the next signal and needs no clearing pass.
module centered_rolling_median_filter
    import crmf_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    crmf_sample_if.sink    sample_in,
    crmf_result_if.source  result_out,
    crmf_cfg_if.sink       cfg
);

    logic [CFG_DATA_BITS-1:0] window_size_reg;
    logic                     residual_mode_reg;
    logic [CNT_BITS-1:0]      n;
    crmf_cmd_t                cmd;

    // Configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg   <= WINDOW_SIZE_RESET;
            residual_mode_reg <= 1'b0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                REG_WINDOW_SIZE:   window_size_reg   <= cfg.data;
                REG_RESIDUAL_MODE: residual_mode_reg <= cfg.data[0];
                default:           ;
            endcase
        end
    end

    // Effective window: zero counts as one, held at the store depth
    always_comb
    begin
        if (window_size_reg == '0)
            n = CNT_BITS'(1);
        else if (32'(window_size_reg) > MAX_WINDOW)
            n = CNT_BITS'(MAX_WINDOW);
        else
            n = CNT_BITS'(window_size_reg);
    end

    crmf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .n         (n),
        .in_valid  (sample_in.valid),
        .in_ready  (sample_in.ready),
        .in_last   (sample_in.last_sample),
        .out_valid (result_out.valid),
        .out_ready (result_out.ready),
        .out_last  (result_out.last_result),
        .cmd       (cmd)
    );

    crmf_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .n         (n),
        .residual  (residual_mode_reg),
        .in_sample (sample_in.sample),
        .value     (result_out.value)
    );

    // Leave idle for the pushes after every accepted sample
    assert property (@(posedge clk) disable iff (!rst_n)
        sample_in.valid && sample_in.ready |=> !sample_in.ready)
        else $error("sample accepted while pushes still pending");

    // Never overwrite a result that has not been taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_out.valid || result_out.ready))
        else $error("pending result overwritten");

    // Rank candidates stay inside the window
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> (CNT_BITS'(cmd.idx) < n))
        else $error("rank candidate outside window");

    // No new sample is taken in the middle of a rank pass
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.cmp |-> !sample_in.ready)
        else $error("input ready during rank pass");

endmodule
